/* rtl/lss_pkg.sv */
// Shared constants and types for the lane steering and speed block.
package lss_pkg;

   // Fraction bits of the angle terms
   localparam int ANGLE_FRAC_BITS = 8;

   // Displacement magnitude times 30 fits in 16 bits
   localparam int MAG_W  = 16;
   // Dividend and quotient width of one angle term
   localparam int QUOT_W = MAG_W + ANGLE_FRAC_BITS;
   // Signed width for line angles, their sum and the steering value
   localparam int SUM_W  = QUOT_W + 3;

   localparam int STEER_W = 15;
   localparam int SPEED_W = 10;
   localparam int POS_W   = 10;
   localparam int CSR_W   = 10;

   localparam int CURVE_LIMIT = 20;
   localparam int END_Y_REF   = 200;
   localparam int SCALE_DEG   = 30;

   localparam int ANGLE_MID = 90 << ANGLE_FRAC_BITS;
   localparam int ANGLE_MAX = 120 << ANGLE_FRAC_BITS;
   localparam int ANGLE_MIN = 60 << ANGLE_FRAC_BITS;

   // Register indexes of the configuration port
   typedef enum logic [2:0] {
      CSR_CAR_WIDTH       = 3'd0,
      CSR_SAFETY_MARGIN   = 3'd1,
      CSR_LANE_WIDTH      = 3'd2,
      CSR_MAX_END_SHIFT   = 3'd3,
      CSR_MAX_START_SHIFT = 3'd4,
      CSR_CURVE_SPEED     = 3'd5,
      CSR_STRAIGHT_SPEED  = 3'd6,
      CSR_LINE_ENABLE     = 3'd7
   } csr_idx_type;

endpackage

/* rtl/lane_steering_and_speed.sv */
// Top level: pipelined steering angle and drive speed from two lane lines.
//
// Usage:
//   req_* carries one item per accepted handshake: visibility, start x and end
//   x,y of the right and left lane lines. rsp_* returns one result item for
//   each: steering angle (1/256 degree), drive speed and the emergency flag.
//   csr_* writes the eight configuration registers; write only while idle.
// Pipeline:
//   Each accepted item passes stage 0, the QUOT_W divider stages, the line
//   angle stage and the output register. One item is accepted every cycle
//   unless stalled. The depth is set by four restoring dividers, one quotient
//   bit per pipeline stage, that form the end and start angle terms of both lines.
// Reset:
//   Synchronous, active high. Clears every stage valid bit and loads the
//   register defaults; payload registers are not reset.
// Stalls:
//   When rsp_ready is low with a result waiting, the whole pipeline holds and
//   req_ready drops; nothing is lost or repeated. When the output register is
//   empty or being taken, req_ready is high.
module lane_steering_and_speed (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic                         req_right_visible,
   input  logic [lss_pkg::POS_W-1:0]    req_right_start_x,
   input  logic [lss_pkg::POS_W-1:0]    req_right_end_x,
   input  logic [lss_pkg::POS_W-1:0]    req_right_end_y,
   input  logic                         req_left_visible,
   input  logic [lss_pkg::POS_W-1:0]    req_left_start_x,
   input  logic [lss_pkg::POS_W-1:0]    req_left_end_x,
   input  logic [lss_pkg::POS_W-1:0]    req_left_end_y,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [lss_pkg::STEER_W-1:0]  rsp_steering_angle,
   output logic [lss_pkg::SPEED_W-1:0]  rsp_drive_speed,
   output logic                         rsp_emergency,
   input  logic                         csr_we,
   input  logic [2:0]                   csr_addr,
   input  logic [lss_pkg::CSR_W-1:0]    csr_wdata
);

   localparam int QW = lss_pkg::QUOT_W;
   localparam int SW = lss_pkg::SUM_W;
   localparam int F  = lss_pkg::ANGLE_FRAC_BITS;

   // Configuration registers
   logic [7:0] car_width_ff, safety_margin_ff, lane_width_ff;
   logic [9:0] max_end_shift_ff, max_start_shift_ff;
   logic [9:0] curve_speed_ff, straight_speed_ff;
   logic [1:0] line_enable_ff;

   logic adv;

   // Pipeline registers: stage 0 is the input stage, stage k holds k quotient bits
   logic                        vld_ff [0:QW];
   logic [9:0]                  rem_ff [0:QW][0:3];
   logic [QW-1:0]               nq_ff  [0:QW][0:3];
   logic [3:0]                  sgn_ff [0:QW];
   logic [1:0]                  use_ff [0:QW];
   logic [lss_pkg::SPEED_W-1:0] spd_ff [0:QW];

   logic [9:0]    rem_in [1:QW][0:3];
   logic [QW-1:0] nq_in  [1:QW][0:3];

   logic [QW:0] term_in [0:3];
   logic [8:0]  base;
   logic [9:0]  left_span;
   logic signed [12:0] off_r, off_l;
   logic [9:0]  div_end, div_start;
   logic [lss_pkg::SPEED_W-1:0] spd_r, spd_l, spd_in;

   // Line angle stage
   logic                        vld_a_ff;
   logic signed [SW-1:0]        ang_r_ff, ang_l_ff;
   logic [lss_pkg::SPEED_W-1:0] spd_a_ff;
   logic signed [SW-1:0]        ang_r_in, ang_l_in;

   // Output stage
   logic                         out_valid_ff;
   logic [lss_pkg::STEER_W-1:0]  steer_ff;
   logic [lss_pkg::SPEED_W-1:0]  speed_ff;
   logic                         emerg_ff;
   logic signed [SW-1:0]         merged, steer_sum, steer_clamped;

   // Sign and scaled magnitude of one displacement term
   function automatic logic [QW:0] disp_term(input logic [9:0] x, input logic [9:0] y,
                                              input logic signed [12:0] off,
                                              input logic with_w);
      logic signed [12:0] d;
      logic signed [12:0] w;
      logic [12:0]        mag;
      logic [lss_pkg::MAG_W-1:0] prod;
      d = $signed({3'b000, x}) - off;
      w = 13'(lss_pkg::END_Y_REF) - $signed({3'b000, y});
      if (with_w) begin
         d = (d < 0) ? (d - w) : (d + w);
      end
      mag  = (d < 0) ? $unsigned(-d) : $unsigned(d);
      prod = lss_pkg::MAG_W'(mag[10:0]) * lss_pkg::MAG_W'(lss_pkg::SCALE_DEG);
      return {(d < 0), prod, {F{1'b0}}};
   endfunction

   // Speed of one line from its slant
   function automatic logic [lss_pkg::SPEED_W-1:0] line_speed(input logic vis,
                                                              input logic [9:0] sx,
                                                              input logic [9:0] ex,
                                                              input logic [9:0] curve,
                                                              input logic [9:0] straight);
      logic [9:0] diff;
      diff = (sx >= ex) ? (sx - ex) : (ex - sx);
      if (!vis) begin
         return '0;
      end
      return (diff > 10'(lss_pkg::CURVE_LIMIT)) ? curve : straight;
   endfunction

   // Signed quotient from magnitude and sign
   function automatic logic signed [SW-1:0] signed_quot(input logic [QW-1:0] q,
                                                         input logic neg);
      logic signed [SW-1:0] v;
      v = $signed({{(SW-QW){1'b0}}, q});
      return neg ? -v : v;
   endfunction

   // Halve with truncation toward zero
   function automatic logic signed [SW-1:0] half_trunc(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] t;
      t = v + SW'(v[SW-1]);
      return t >>> 1;
   endfunction

   assign adv       = !out_valid_ff || rsp_ready;
   assign req_ready = adv;

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         car_width_ff       <= 8'd15;
         safety_margin_ff   <= 8'd8;
         lane_width_ff      <= 8'd45;
         max_end_shift_ff   <= 10'd400;
         max_start_shift_ff <= 10'd20;
         curve_speed_ff     <= 10'd384;
         straight_speed_ff  <= 10'd384;
         line_enable_ff     <= 2'd3;
      end else if (csr_we) begin
         case (csr_addr)
            lss_pkg::CSR_CAR_WIDTH:       car_width_ff       <= csr_wdata[7:0];
            lss_pkg::CSR_SAFETY_MARGIN:   safety_margin_ff   <= csr_wdata[7:0];
            lss_pkg::CSR_LANE_WIDTH:      lane_width_ff      <= csr_wdata[7:0];
            lss_pkg::CSR_MAX_END_SHIFT:   max_end_shift_ff   <= csr_wdata;
            lss_pkg::CSR_MAX_START_SHIFT: max_start_shift_ff <= csr_wdata;
            lss_pkg::CSR_CURVE_SPEED:     curve_speed_ff     <= csr_wdata;
            lss_pkg::CSR_STRAIGHT_SPEED:  straight_speed_ff  <= csr_wdata;
            lss_pkg::CSR_LINE_ENABLE:     line_enable_ff     <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   // Line offsets and divisors, a zero divisor counts as one
   assign base      = {1'b0, car_width_ff} + {1'b0, safety_margin_ff};
   assign left_span = {1'b0, base} + {2'b00, lane_width_ff};
   assign off_r     = $signed({4'b0000, base});
   assign off_l     = -$signed({3'b000, left_span});
   assign div_end   = (max_end_shift_ff == '0) ? 10'd1 : max_end_shift_ff;
   assign div_start = (max_start_shift_ff == '0) ? 10'd1 : max_start_shift_ff;

   // Form the four dividends and the speed
   always_comb begin
      term_in[0] = disp_term(req_right_end_x, req_right_end_y, off_r, 1'b1);
      term_in[1] = disp_term(req_right_start_x, req_right_end_y, off_r, 1'b0);
      term_in[2] = disp_term(req_left_end_x, req_left_end_y, off_l, 1'b1);
      term_in[3] = disp_term(req_left_start_x, req_left_end_y, off_l, 1'b0);
      spd_r  = line_speed(req_right_visible, req_right_start_x, req_right_end_x,
                          curve_speed_ff, straight_speed_ff);
      spd_l  = line_speed(req_left_visible, req_left_start_x, req_left_end_x,
                          curve_speed_ff, straight_speed_ff);
      spd_in = (spd_r > spd_l) ? spd_r : spd_l;
   end

   // Load stage 0
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (adv) begin
         vld_ff[0] <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int j = 0; j < 4; j++) begin
            rem_ff[0][j] <= '0;
            nq_ff[0][j]  <= term_in[j][QW-1:0];
            sgn_ff[0][j] <= term_in[j][QW];
         end
         use_ff[0] <= {line_enable_ff[1] & req_left_visible,
                       line_enable_ff[0] & req_right_visible};
         spd_ff[0] <= spd_in;
      end
   end

   // One restoring step per stage for each divider
   always_comb begin
      logic [10:0] r11;
      logic [10:0] dv;
      for (int k = 0; k < QW; k++) begin
         for (int j = 0; j < 4; j++) begin
            dv  = {1'b0, ((j % 2) == 0) ? div_end : div_start};
            r11 = {rem_ff[k][j], nq_ff[k][j][QW-1]};
            if (r11 >= dv) begin
               rem_in[k+1][j] = 10'(r11 - dv);
               nq_in[k+1][j]  = {nq_ff[k][j][QW-2:0], 1'b1};
            end else begin
               rem_in[k+1][j] = r11[9:0];
               nq_in[k+1][j]  = {nq_ff[k][j][QW-2:0], 1'b0};
            end
         end
      end
   end

   // Advance the divider stages
   for (genvar k = 1; k <= QW; k++) begin : g_div
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k] <= 1'b0;
         end else if (adv) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            for (int j = 0; j < 4; j++) begin
               rem_ff[k][j] <= rem_in[k][j];
               nq_ff[k][j]  <= nq_in[k][j];
            end
            sgn_ff[k] <= sgn_ff[k-1];
            use_ff[k] <= use_ff[k-1];
            spd_ff[k] <= spd_ff[k-1];
         end
      end
   end

   // Combine end and start terms into line angles
   always_comb begin
      ang_r_in = half_trunc(signed_quot(nq_ff[QW][0], sgn_ff[QW][0]) +
                            signed_quot(nq_ff[QW][1], sgn_ff[QW][1]));
      ang_l_in = half_trunc(signed_quot(nq_ff[QW][2], sgn_ff[QW][2]) +
                            signed_quot(nq_ff[QW][3], sgn_ff[QW][3]));
      if (!use_ff[QW][0]) begin
         ang_r_in = '0;
      end
      if (!use_ff[QW][1]) begin
         ang_l_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_a_ff <= 1'b0;
      end else if (adv) begin
         vld_a_ff <= vld_ff[QW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         ang_r_ff <= ang_r_in;
         ang_l_ff <= ang_l_in;
         spd_a_ff <= spd_ff[QW];
      end
   end

   // Merge the two angles, offset to straight ahead and clamp
   always_comb begin
      if (ang_r_ff == '0) begin
         merged = ang_l_ff;
      end else if (ang_l_ff == '0) begin
         merged = ang_r_ff;
      end else begin
         merged = half_trunc(ang_l_ff + ang_r_ff);
      end
      steer_sum = SW'(lss_pkg::ANGLE_MID) + merged;
      if (steer_sum > SW'(lss_pkg::ANGLE_MAX)) begin
         steer_clamped = SW'(lss_pkg::ANGLE_MAX);
      end else if (steer_sum < SW'(lss_pkg::ANGLE_MIN)) begin
         steer_clamped = SW'(lss_pkg::ANGLE_MIN);
      end else begin
         steer_clamped = steer_sum;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= vld_a_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         steer_ff <= steer_clamped[lss_pkg::STEER_W-1:0];
         speed_ff <= spd_a_ff;
         emerg_ff <= (spd_a_ff == '0);
      end
   end

   assign rsp_valid          = out_valid_ff;
   assign rsp_steering_angle = steer_ff;
   assign rsp_drive_speed    = speed_ff;
   assign rsp_emergency      = emerg_ff;

endmodule

/* rtl/lss_checker.sv */
// Port-level checks for the lane steering and speed block, bound to the top level.
module lss_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [lss_pkg::STEER_W-1:0]  rsp_steering_angle,
   input logic [lss_pkg::SPEED_W-1:0]  rsp_drive_speed,
   input logic                         rsp_emergency
);

   // Emergency tracks a zero speed
   a_emerg: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_emergency == (rsp_drive_speed == '0)))
      else $error("emergency does not match zero speed");

   // Steering stays inside the clamp window
   a_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_steering_angle >= lss_pkg::STEER_W'(lss_pkg::ANGLE_MIN)) &&
                     (rsp_steering_angle <= lss_pkg::STEER_W'(lss_pkg::ANGLE_MAX))))
      else $error("steering angle outside clamp window");

   // An empty output register never blocks the input
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with no result waiting");

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_steering_angle) &&
                                     $stable(rsp_drive_speed)))
      else $error("stalled result changed");

endmodule

bind lane_steering_and_speed lss_checker u_lss_checker (
   .clock              (clock),
   .reset              (reset),
   .req_ready          (req_ready),
   .rsp_valid          (rsp_valid),
   .rsp_ready          (rsp_ready),
   .rsp_steering_angle (rsp_steering_angle),
   .rsp_drive_speed    (rsp_drive_speed),
   .rsp_emergency      (rsp_emergency)
);
